FILE: design/csa_pkg.sv
// Shared types and constants of the contiguous slot allocator.
// No dependencies; all other design files except csa_ram refer to it by scoped names.
package csa_pkg;

  localparam int SLOTS_DEF       = 256;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SIZE_W          = 9;
  localparam int LIFE_W          = 16;
  localparam int ID_W            = 16;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 9;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;
  localparam logic [1:0] POL_HOLD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 4'd1;

  localparam logic [1:0]        POLICY_RST = POL_FIRST;
  localparam logic [SIZE_W-1:0] SLOTS_RST  = 9'd256;

  typedef struct packed {
    logic [SIZE_W-1:0] req_size;
    logic [LIFE_W-1:0] req_life;
    logic [LIFE_W-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [ID_W-1:0]   granted_id;
    logic [7:0]        start_slot;
    logic [8:0]        busy_slots;
    logic              dropped;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        policy;
    logic [SIZE_W-1:0] slots_in_use;
  } cfg_t;

endpackage

FILE: design/csa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/csa_cmd_fifo.sv
// Two-entry command queue between the input port and the allocation engine.
// Depends on csa_pkg for the input item type.
module csa_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csa_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output csa_pkg::in_item_t cmd_o
);

  csa_pkg::in_item_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

endmodule

FILE: design/csa_back.sv
// Allocation engine: pending request queue, free-run scan and aging sweep.
// Depends on csa_pkg and csa_ram.
module csa_back #(
  parameter int SLOTS       = csa_pkg::SLOTS_DEF,
  parameter int QUEUE_DEPTH = csa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  csa_pkg::in_item_t  cmd_i,
  output logic               cmd_pop_o,
  input  csa_pkg::cfg_t      cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csa_pkg::out_item_t out_o
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int SW = (CW > csa_pkg::SIZE_W) ? CW : csa_pkg::SIZE_W;
  localparam int EW = SW + 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_HEAD, ST_SCAN, ST_AGE} state_e;

  state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic [csa_pkg::ID_W-1:0] id_q, id_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [SLOTS-1:0] busy_q, busy_d;
  logic [CW-1:0] p_q, p_d, i_q, i_d, run_len_q, run_len_d, run_start_q, run_start_d;
  logic [CW-1:0] best_len_q, best_len_d, best_start_q, best_start_d;
  logic best_v_q, best_v_d, phase_q, phase_d, grant_q, grant_d, drop_q, drop_d;
  logic [CW-1:0] start_q, start_d, cntb_q, cntb_d;
  logic [csa_pkg::SIZE_W-1:0] h_size_q, h_size_d;
  logic [csa_pkg::LIFE_W-1:0] h_life_q, h_life_d, el_q, el_d;
  logic [csa_pkg::ID_W-1:0] h_id_q, h_id_d;
  logic rd_v_q, rd_v_d;
  logic [IW-1:0] rd_a_q, rd_a_d;
  logic out_valid_q, out_valid_d;
  csa_pkg::out_item_t out_q, out_d;

  logic [csa_pkg::SIZE_W-1:0] q_size_q [QUEUE_DEPTH];
  logic [csa_pkg::LIFE_W-1:0] q_life_q [QUEUE_DEPTH];
  logic [csa_pkg::ID_W-1:0]   q_id_q   [QUEUE_DEPTH];
  logic q_we;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [csa_pkg::LIFE_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] len;

  csa_ram #(.WIDTH(csa_pkg::LIFE_W), .DEPTH(SLOTS)) u_life_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign len = (SW'(cfg_i.slots_in_use) > SW'(SLOTS)) ? CW'(SLOTS) : CW'(cfg_i.slots_in_use);

  function automatic logic [QW-1:0] qwrap(input logic [QW-1:0] v);
    qwrap = (v == QW'(QUEUE_DEPTH - 1)) ? '0 : v + QW'(1);
  endfunction

  always_comb begin
    logic [SW-1:0] sz;
    logic [CW-1:0] ns, nl, fs, np;
    logic [csa_pkg::SIZE_W-1:0] hs;
    logic fnd, stop, inr, alive, go_age;
    logic [csa_pkg::LIFE_W-1:0] cur;

    state_d = state_q; cnt_d = cnt_q; head_d = head_q; tail_d = tail_q; id_d = id_q;
    ptr_d = ptr_q; busy_d = busy_q; p_d = p_q; i_d = i_q; run_len_d = run_len_q;
    run_start_d = run_start_q; best_len_d = best_len_q; best_start_d = best_start_q;
    best_v_d = best_v_q; phase_d = phase_q; grant_d = grant_q; drop_d = drop_q;
    start_d = start_q; cntb_d = cntb_q; h_size_d = h_size_q; h_life_d = h_life_q;
    el_d = el_q; h_id_d = h_id_q; rd_v_d = rd_v_q; rd_a_d = rd_a_q;
    out_valid_d = out_valid_q; out_d = out_q;
    cmd_pop_o = 1'b0; q_we = 1'b0;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    sz = SW'(h_size_q); ns = '0; nl = '0; fs = '0; np = '0; hs = '0;
    fnd = 1'b0; stop = 1'b0; inr = 1'b0; alive = 1'b0; go_age = 1'b0; cur = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          el_d      = cmd_i.elapsed;
          grant_d   = 1'b0;
          start_d   = '0;
          h_size_d  = '0;
          if (cnt_q == NW'(QUEUE_DEPTH)) begin
            drop_d = 1'b1;
          end else begin
            drop_d = 1'b0;
            q_we   = 1'b1;
            id_d   = id_q + 16'd1;
            tail_d = qwrap(tail_q);
            cnt_d  = cnt_q + NW'(1);
          end
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (cnt_q == '0) begin
          go_age = 1'b1;
        end else begin
          hs       = q_size_q[head_q];
          h_size_d = hs;
          h_life_d = q_life_q[head_q];
          h_id_d   = q_id_q[head_q];
          if (hs == '0) begin
            if (cfg_i.policy != csa_pkg::POL_HOLD) begin
              grant_d = 1'b1;
              head_d  = qwrap(head_q);
              cnt_d   = cnt_q - NW'(1);
            end
            go_age = 1'b1;
          end else if (cfg_i.policy == csa_pkg::POL_HOLD) begin
            go_age = 1'b1;
          end else begin
            p_d       = (CW'(ptr_q) >= len) ? '0 : CW'(ptr_q);
            i_d       = (cfg_i.policy == csa_pkg::POL_NEXT) ? p_d : '0;
            run_len_d = '0;
            best_v_d  = 1'b0;
            phase_d   = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (i_q >= len) begin
          if (cfg_i.policy == csa_pkg::POL_BEST) begin
            if (run_len_q != '0 && SW'(run_len_q) >= sz &&
                (!best_v_q || run_len_q < best_len_q)) begin
              fnd = 1'b1;
              fs  = run_start_q;
            end else if (best_v_q) begin
              fnd = 1'b1;
              fs  = best_start_q;
            end else begin
              stop = 1'b1;
            end
          end else if (cfg_i.policy == csa_pkg::POL_NEXT && !phase_q) begin
            // wrap: search again from slot zero, starts limited to below the pointer
            phase_d   = 1'b1;
            i_d       = '0;
            run_len_d = '0;
          end else begin
            stop = 1'b1;
          end
        end else begin
          if (!busy_q[i_q[IW-1:0]]) begin
            ns = (run_len_q == '0) ? i_q : run_start_q;
            nl = run_len_q + CW'(1);
            if (cfg_i.policy == csa_pkg::POL_NEXT && phase_q && run_len_q == '0 &&
                i_q >= p_q) begin
              stop = 1'b1;
            end else if (cfg_i.policy != csa_pkg::POL_BEST && SW'(nl) >= sz) begin
              fnd = 1'b1;
              fs  = ns;
            end else begin
              run_len_d   = nl;
              run_start_d = ns;
            end
          end else begin
            if (cfg_i.policy == csa_pkg::POL_BEST && run_len_q != '0 &&
                SW'(run_len_q) >= sz && (!best_v_q || run_len_q < best_len_q)) begin
              best_v_d     = 1'b1;
              best_len_d   = run_len_q;
              best_start_d = run_start_q;
            end
            if (cfg_i.policy == csa_pkg::POL_NEXT && phase_q && i_q >= p_q) begin
              stop = 1'b1;
            end
            run_len_d = '0;
          end
          i_d = i_q + CW'(1);
        end
        if (fnd) begin
          grant_d = 1'b1;
          start_d = fs;
          head_d  = qwrap(head_q);
          cnt_d   = cnt_q - NW'(1);
          if (cfg_i.policy == csa_pkg::POL_NEXT) begin
            np    = fs + CW'(1);
            ptr_d = (np >= len) ? '0 : np[IW-1:0];
          end
          go_age = 1'b1;
        end else if (stop) begin
          if (cfg_i.policy == csa_pkg::POL_NEXT) begin
            ptr_d = p_q[IW-1:0];
          end
          go_age = 1'b1;
        end
      end
      ST_AGE: begin
        // retire the slot read last cycle: load grant, age, write back
        if (rd_v_q) begin
          inr = grant_q && (EW'(rd_a_q) >= EW'(start_q)) &&
                (EW'(rd_a_q) < EW'(start_q) + EW'(h_size_q));
          cur = inr ? h_life_q : (busy_q[rd_a_q] ? ram_rdata : '0);
          alive = (cur > el_q);
          ram_we    = 1'b1;
          ram_waddr = rd_a_q;
          ram_wdata = alive ? cur - el_q : '0;
          busy_d[rd_a_q] = alive;
          cntb_d = cntb_q + CW'(alive);
        end
        if (i_q < len) begin
          ram_raddr = i_q[IW-1:0];
          rd_v_d    = 1'b1;
          rd_a_d    = i_q[IW-1:0];
          i_d       = i_q + CW'(1);
        end else begin
          rd_v_d = 1'b0;
          if (!rd_v_q) begin
            out_valid_d      = 1'b1;
            out_d.granted    = grant_q;
            out_d.granted_id = grant_q ? h_id_q : '0;
            out_d.start_slot = 8'(start_q);
            out_d.busy_slots = 9'(cntb_q);
            out_d.dropped    = drop_q;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (go_age) begin
      i_d     = '0;
      rd_v_d  = 1'b0;
      cntb_d  = '0;
      state_d = ST_AGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      id_q        <= '0;
      ptr_q       <= '0;
      busy_q      <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      id_q        <= id_d;
      ptr_q       <= ptr_d;
      busy_q      <= busy_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; i_q <= i_d; run_len_q <= run_len_d; run_start_q <= run_start_d;
    best_len_q <= best_len_d; best_start_q <= best_start_d; best_v_q <= best_v_d;
    phase_q <= phase_d; grant_q <= grant_d; drop_q <= drop_d; start_q <= start_d;
    cntb_q <= cntb_d; h_size_q <= h_size_d; h_life_q <= h_life_d; el_q <= el_d;
    h_id_q <= h_id_d; rd_a_q <= rd_a_d; out_q <= out_d;
    if (q_we) begin
      q_size_q[tail_q] <= cmd_i.req_size;
      q_life_q[tail_q] <= cmd_i.req_life;
      q_id_q[tail_q]   <= id_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.granted) |-> (out_q.granted_id == '0 && out_q.start_slot == '0))
    else $error("ungranted result carries id or start");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_HEAD && out_valid_q == 1'b0))
    else $error("command taken outside idle");

  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AGE) |-> (cntb_q <= i_q))
    else $error("busy count exceeds swept slots");

endmodule

FILE: design/contiguous_slot_allocator_core.sv
// Contiguous slot allocator: top level with configuration registers.
// Depends on csa_pkg, csa_cmd_fifo and csa_back.
// A request passes the enqueue step, the head check, a free-run scan when one runs
// and the aging sweep before its result is valid; the scan and the sweep take one
// slot per cycle, and the wrapped pass of next fit may cover the slots twice. A new
// request is taken only once the engine is idle and the previous result was taken.
// Reset: asynchronous, active low; all slots free, queue empty, no clearing pass.
module contiguous_slot_allocator_core #(
  parameter int SLOTS       = csa_pkg::SLOTS_DEF,
  parameter int QUEUE_DEPTH = csa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  csa_pkg::in_item_t                in_item_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output csa_pkg::out_item_t               out_item_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [csa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [csa_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  csa_pkg::cfg_t     cfg_q, cfg_d;
  csa_pkg::in_item_t cmd;
  logic              cmd_valid, cmd_pop;

  // Always take configuration; user writes only while the block is idle, unenforced.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        csa_pkg::CFG_POLICY: cfg_d.policy       = cfg_data_i[1:0];
        csa_pkg::CFG_SLOTS:  cfg_d.slots_in_use = cfg_data_i;
        default:             cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy       <= csa_pkg::POLICY_RST;
      cfg_q.slots_in_use <= csa_pkg::SLOTS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: buffer up to two requests so the port can accept while a result waits.
  csa_cmd_fifo u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Back: enqueue or drop, try the head, then age every active slot.
  csa_back #(
    .SLOTS       (SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_item_o)
  );

endmodule

FILE: test/contiguous_slot_allocator_core_tb.sv
// Self-checking testbench of contiguous_slot_allocator_core.
// Depends on csa_pkg and the allocator RTL; a built-in slot map model predicts
// every result, checked as requests flow through bursty and stalled channels.
module contiguous_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = csa_pkg::SLOTS_DEF;
  localparam int QDEPTH    = csa_pkg::QUEUE_DEPTH_DEF;
  localparam int IDLE_MAX  = 20000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYC = 2 * NSLOT + 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  csa_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  csa_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [csa_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [csa_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  contiguous_slot_allocator_core i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Slot map model: lifetimes, request FIFO, next-fit pointer and id counter.
  // ---------------------------------------------------------------------------
  logic [csa_pkg::LIFE_W-1:0] slot_left [NSLOT];
  logic [csa_pkg::SIZE_W-1:0] fifo_size [QDEPTH];
  logic [csa_pkg::LIFE_W-1:0] fifo_life [QDEPTH];
  logic [csa_pkg::ID_W-1:0]   fifo_id   [QDEPTH];
  int                         fifo_rd, fifo_wr, fifo_cnt;
  logic [csa_pkg::ID_W-1:0]   seq_ctr;
  int                         roving_ptr;
  logic [1:0]                 m_policy;
  logic [csa_pkg::SIZE_W-1:0] m_slots;

  csa_pkg::in_item_t  req_q[$];     // requests not yet handed to the block
  csa_pkg::out_item_t grant_q[$];   // predicted results, oldest first
  int                 fail_cnt = 0;

  function automatic int free_run(int s, int len);
    int j;
    j = s;
    while (j < len && slot_left[j] == 0) j++;
    return j - s;
  endfunction

  // Lowest start in [lo, hi) whose free run is long enough, -1 when none.
  function automatic int lowest_fit(int lo, int hi, int len, int size);
    int i, r;
    i = lo;
    while (i < hi && i < len) begin
      if (slot_left[i] == 0) begin
        r = free_run(i, len);
        if (r >= size) return i;
        i = i + r + 1;
      end else begin
        i++;
      end
    end
    return -1;
  endfunction

  // Smallest maximal free run that fits; lowest start wins a tie.
  function automatic int tightest_fit(int len, int size);
    int i, r, best, best_len;
    best = -1;
    best_len = 0;
    i = 0;
    while (i < len) begin
      if (slot_left[i] == 0) begin
        r = free_run(i, len);
        if (r >= size && (best < 0 || r < best_len)) begin
          best = i;
          best_len = r;
        end
        i += r;
      end else begin
        i++;
      end
    end
    return best;
  endfunction

  function automatic csa_pkg::out_item_t place_request(csa_pkg::in_item_t req);
    csa_pkg::out_item_t res;
    int len, pos, p, sz, busy;
    res = '0;
    len = (m_slots > NSLOT) ? NSLOT : int'(m_slots);
    if (fifo_cnt >= QDEPTH) begin
      res.dropped = 1'b1;
    end else begin
      seq_ctr++;
      fifo_size[fifo_wr] = req.req_size;
      fifo_life[fifo_wr] = req.req_life;
      fifo_id[fifo_wr]   = seq_ctr;
      fifo_wr = (fifo_wr + 1) % QDEPTH;
      fifo_cnt++;
    end
    if (fifo_cnt > 0) begin
      sz  = int'(fifo_size[fifo_rd]);
      pos = -1;
      if (sz == 0) begin
        if (m_policy != csa_pkg::POL_HOLD) pos = 0;
      end else begin
        case (m_policy)
          csa_pkg::POL_FIRST: begin
            pos = lowest_fit(0, len, len, sz);
          end
          csa_pkg::POL_BEST: begin
            pos = tightest_fit(len, sz);
          end
          csa_pkg::POL_NEXT: begin
            // Search from the pointer, then wrap to the slots below it.
            p = (roving_ptr >= len) ? 0 : roving_ptr;
            pos = lowest_fit(p, len, len, sz);
            if (pos < 0) pos = lowest_fit(0, p, len, sz);
            if (pos >= 0) roving_ptr = (pos + 1 >= len) ? 0 : pos + 1;
            else roving_ptr = p;
          end
          default: pos = -1;
        endcase
      end
      if (pos >= 0) begin
        for (int i = pos; i < pos + sz && i < len; i++) slot_left[i] = fifo_life[fifo_rd];
        res.granted    = 1'b1;
        res.granted_id = fifo_id[fifo_rd];
        res.start_slot = pos[7:0];
        fifo_rd = (fifo_rd + 1) % QDEPTH;
        fifo_cnt--;
      end
    end
    // Age the live slots; anything at or below zero frees.
    busy = 0;
    for (int i = 0; i < len; i++) begin
      if (slot_left[i] > req.elapsed) begin
        slot_left[i] = slot_left[i] - req.elapsed;
        busy++;
      end else begin
        slot_left[i] = '0;
      end
    end
    res.busy_slots = busy[8:0];
    return res;
  endfunction

  initial begin
    foreach (slot_left[i]) slot_left[i] = '0;
    fifo_rd = 0;
    fifo_wr = 0;
    fifo_cnt = 0;
    seq_ctr = '0;
    roving_ptr = 0;
    m_policy = csa_pkg::POLICY_RST;
    m_slots = csa_pkg::SLOTS_RST;
  end

  // ---------------------------------------------------------------------------
  // Handshake observer: predict on each accepted request, check each result,
  // mirror register writes, and run the stall watchdog.
  // ---------------------------------------------------------------------------
  logic req_taken = 1'b0;
  int   quiet_cyc = 0;

  always @(posedge clk_i) begin
    csa_pkg::out_item_t want;
    req_taken = 1'b0;
    if (rst_ni) begin
      quiet_cyc++;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == csa_pkg::CFG_POLICY) m_policy = cfg_data_i[1:0];
        else if (cfg_index_i == csa_pkg::CFG_SLOTS) m_slots = cfg_data_i;
        quiet_cyc = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        grant_q.push_back(place_request(in_item_i));
        void'(req_q.pop_front());
        req_taken = 1'b1;
        quiet_cyc = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cyc = 0;
        if (grant_q.size() == 0) begin
          $error("unexpected result item: %p", out_item_o);
          fail_cnt++;
        end else begin
          want = grant_q.pop_front();
          if (out_item_o.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_item_o.granted);
            fail_cnt++;
          end
          if (out_item_o.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d", want.granted_id,
                   out_item_o.granted_id);
            fail_cnt++;
          end
          if (out_item_o.start_slot !== want.start_slot) begin
            $error("start_slot: expected %0d, got %0d", want.start_slot,
                   out_item_o.start_slot);
            fail_cnt++;
          end
          if (out_item_o.busy_slots !== want.busy_slots) begin
            $error("busy_slots: expected %0d, got %0d", want.busy_slots,
                   out_item_o.busy_slots);
            fail_cnt++;
          end
          if (out_item_o.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, out_item_o.dropped);
            fail_cnt++;
          end
        end
      end
      if (quiet_cyc >= IDLE_MAX) begin
        $display("contiguous_slot_allocator_core regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. A
  // presented item is held until it is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    logic              nxt_valid;
    csa_pkg::in_item_t nxt_item;
    nxt_valid = in_valid_i;
    nxt_item  = in_item_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        nxt_valid = 1'b0;
      end else if (req_q.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_item  = req_q[0];
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            5:       gap_left = $urandom_range(100, 700);  // lands on late scan cycles
            default: gap_left = $urandom_range(1, 20);
          endcase
        end
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid_i <= nxt_valid;
    in_item_i  <= nxt_item;
  end

  // Result stall: modes of random length - open, random, mostly stalled.
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= $urandom_range(0, 1);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(int size, int life, int elapsed);
    csa_pkg::in_item_t it;
    it.req_size = size[csa_pkg::SIZE_W-1:0];
    it.req_life = life[csa_pkg::LIFE_W-1:0];
    it.elapsed  = elapsed[csa_pkg::LIFE_W-1:0];
    req_q.push_back(it);
  endtask

  task automatic write_reg(logic [csa_pkg::CFG_IDX_W-1:0] idx, int data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[csa_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off until every request is taken and every result has come back.
  task automatic drain();
    @(posedge clk_i);
    while (req_q.size() != 0 || grant_q.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  // Random request sized for the current slot count; mostly well placed,
  // with a few empty, full-width and oversize requests mixed in.
  task automatic add_random_req(int len);
    int size, life, el, top;
    top = (len < 4) ? 1 : len / 4;
    case ($urandom_range(0, 49))
      0, 1:    size = 0;
      2:       size = len;
      3:       size = len + 1;
      4:       size = (len >= 8) ? $urandom_range(len / 2, len) : 1;
      default: size = $urandom_range(1, top);
    endcase
    if (size > NSLOT) size = NSLOT;
    case ($urandom_range(0, 19))
      0:       life = 0;
      1:       life = $urandom_range(0, 65535);
      2:       life = 65535;
      default: life = $urandom_range(1, 1500);
    endcase
    case ($urandom_range(0, 19))
      0:       el = $urandom_range(0, 65535);
      1:       el = 65535;
      2, 3:    el = 0;
      default: el = $urandom_range(0, 64);
    endcase
    add_req(size, life, el);
  endtask

  initial begin
    int pol_tab[12]  = '{csa_pkg::POL_BEST, csa_pkg::POL_NEXT, csa_pkg::POL_FIRST,
                         csa_pkg::POL_HOLD, csa_pkg::POL_NEXT, csa_pkg::POL_BEST,
                         csa_pkg::POL_FIRST, csa_pkg::POL_NEXT, csa_pkg::POL_BEST,
                         csa_pkg::POL_FIRST, csa_pkg::POL_NEXT, csa_pkg::POL_BEST};
    int slot_tab[12] = '{32, 16, 8, 24, 1, 256, 0, 511, 3, 64, 40, 128};
    int len;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: first fit over all slots.
    write_reg(csa_pkg::CFG_POLICY, csa_pkg::POL_FIRST);
    write_reg(csa_pkg::CFG_SLOTS, 256);
    add_req(1, 1, 0);          // one slot, shortest life
    add_req(1, 65535, 0);      // longest life
    add_req(255, 65535, 0);    // too large beside the first two; blocks the head until slots free
    add_req(1, 10, 0);         // waits behind the blocked head
    add_req(2, 10, 65535);     // largest aging frees everything
    add_req(0, 0, 0);          // empty request, zero life
    add_req(256, 3, 1);        // whole map
    add_req(4, 0, 0);          // granted but stays free
    add_req(8, 100, 0);
    add_req(16, 100, 0);
    add_req(8, 100, 0);
    add_req(4, 100, 0);
    add_req(2, 50, 49);
    drain();

    // Hold policy: nothing placed, queue overflows and drops.
    write_reg(csa_pkg::CFG_POLICY, csa_pkg::POL_HOLD);
    for (int i = 0; i < QDEPTH + 4; i++) add_req(i % 3, 300, 0);
    drain();

    // Random phases across placement rules and slot counts.
    foreach (pol_tab[ph]) begin
      write_reg(csa_pkg::CFG_POLICY, pol_tab[ph]);
      write_reg(csa_pkg::CFG_SLOTS, slot_tab[ph]);
      len = (slot_tab[ph] > NSLOT) ? NSLOT : slot_tab[ph];
      for (int i = 0; i < 105; i++) add_random_req(len);
      drain();
    end

    // Oversize request last: it blocks the head for good and later ones drop.
    write_reg(csa_pkg::CFG_POLICY, csa_pkg::POL_FIRST);
    add_req(300, 5, 1);
    for (int i = 0; i < QDEPTH + 3; i++) add_req(1, 5, 1);
    drain();

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0 && grant_q.size() == 0) begin
      $display("contiguous_slot_allocator_core regression: pass");
    end else begin
      $display("contiguous_slot_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
